/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SITOA_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sitoa: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SITOA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sitoa: next-cycle check failed");

`endif

/* hdl/sitoa_pkg.sv */
// ----------------------------------------------------------------------------
// sitoa_pkg
// Constants and helper functions for the signed decimal text converter.
// ----------------------------------------------------------------------------
package sitoa_pkg;

	// Default width of the input value.
	localparam int VALUE_BITS_DEF = 32;

	// Magnitude bits consumed by one double-dabble pipeline stage.
	localparam int STEP_BITS = 4;

	// Width of one BCD digit.
	localparam int DIGIT_W = 4;

	// ASCII codes.
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;

	// Decimal digits needed for a magnitude of up to 2**(bits-1).
	// 1233/4096 approximates log10(2) closely enough for up to 64 bits.
	function automatic int num_digits(input int bits);
		return (((bits - 1) * 1233) >> 12) + 1;
	endfunction

endpackage

/* hdl/signed_int_to_decimal_ascii_core.sv */
// A start transfer passes the input register, the double-dabble stages and the
// length stage register; the serializer then strobes one character per cycle.
// The serializer takes a new value as the final digit goes out; the pipeline
// of ceil(VALUE_BITS/4) double-dabble stages can take a value every cycle
// unless busy. The receiver cannot stall; busy backs up the pipeline. Reset
// clears all valid bits and the serializer; no clearing pass is needed.
`include "assert_macros.svh"

// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core
// Signed binary to decimal ASCII text converter, with a pipelined
// double-dabble front end and a character serializer.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_core #(
	parameter int VALUE_BITS = sitoa_pkg::VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [VALUE_BITS-1:0] value,
	output logic                  strobe,
	output logic [7:0]            character,
	output logic                  last
);

	localparam int NSTG   = (VALUE_BITS + sitoa_pkg::STEP_BITS - 1) / sitoa_pkg::STEP_BITS;
	localparam int MAG_W  = NSTG * sitoa_pkg::STEP_BITS;
	localparam int DIGITS = sitoa_pkg::num_digits(VALUE_BITS);
	localparam int BCD_W  = DIGITS * sitoa_pkg::DIGIT_W;
	localparam int NDIG_W = $clog2(DIGITS + 1);

	logic                  adv;
	logic                  ser_ready;
	logic                  ser_load;
	logic                  neg_c;
	logic [VALUE_BITS-1:0] mag_c;

	logic                  dab_valid [0:NSTG];
	logic                  dab_neg   [0:NSTG];
	logic [MAG_W-1:0]      dab_mag   [0:NSTG];
	logic [BCD_W-1:0]      dab_bcd   [0:NSTG];

	logic                  valid_s1;
	logic                  neg_s1;
	logic [MAG_W-1:0]      mag_s1;

	logic                  len_valid_s;
	logic                  len_neg_s;
	logic [BCD_W-1:0]      len_bcd_s;
	logic [NDIG_W-1:0]     len_ndig_s;
	logic [NDIG_W-1:0]     ndig_c;

	// The whole pipeline moves unless the last stage waits on the serializer.
	assign ser_load = len_valid_s && ser_ready;
	assign adv      = !len_valid_s || ser_ready;
	assign busy     = !adv;

	// Sign and magnitude; the most negative value wraps to 2**(VALUE_BITS-1).
	assign neg_c = value[VALUE_BITS-1];
	assign mag_c = neg_c ? (~value + 1'b1) : value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s1 <= neg_c;
			mag_s1 <= MAG_W'(mag_c);
		end
	end

	assign dab_valid[0] = valid_s1;
	assign dab_neg[0]   = neg_s1;
	assign dab_mag[0]   = mag_s1;
	assign dab_bcd[0]   = '0;

	// Double-dabble stages, STEP_BITS magnitude bits each.
	for (genvar g = 0; g < NSTG; g++) begin : g_dab
		sitoa_dabble_stage #(
			.MAG_W  (MAG_W),
			.DIGITS (DIGITS)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.in_valid (dab_valid[g]),
			.in_neg   (dab_neg[g]),
			.in_mag   (dab_mag[g]),
			.in_bcd   (dab_bcd[g]),
			.valid_s1 (dab_valid[g+1]),
			.neg_s1   (dab_neg[g+1]),
			.mag_s1   (dab_mag[g+1]),
			.bcd_s1   (dab_bcd[g+1])
		);
	end

	// Count of significant digits; zero still shows one digit.
	always_comb begin
		ndig_c = NDIG_W'(1);
		for (int i = 0; i < DIGITS; i++) begin
			if (dab_bcd[NSTG][i*sitoa_pkg::DIGIT_W +: sitoa_pkg::DIGIT_W] != '0) begin
				ndig_c = NDIG_W'(i + 1);
			end
		end
	end

	// Length stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_valid_s <= 1'b0;
		end else if (adv) begin
			len_valid_s <= dab_valid[NSTG];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			len_neg_s  <= dab_neg[NSTG];
			len_bcd_s  <= dab_bcd[NSTG];
			len_ndig_s <= ndig_c;
		end
	end

	// Character output.
	sitoa_serializer #(
		.DIGITS (DIGITS),
		.NDIG_W (NDIG_W)
	) u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (ser_load),
		.neg       (len_neg_s),
		.bcd       (len_bcd_s),
		.ndig      (len_ndig_s),
		.ready     (ser_ready),
		.strobe    (strobe),
		.character (character),
		.last      (last)
	);

	// Every strobed character is a minus sign or a decimal digit.
	`SITOA_ASSERT_SAME(a_char_legal, strobe, (character == sitoa_pkg::CHAR_MINUS) || ((character >= sitoa_pkg::CHAR_ZERO) && (character <= sitoa_pkg::CHAR_NINE)))
	// A minus sign is always followed by at least one digit.
	`SITOA_ASSERT_SAME(a_minus_not_last, strobe && (character == sitoa_pkg::CHAR_MINUS), !last)
	// An accepted start transfer enters the first stage.
	`SITOA_ASSERT_NEXT(a_start_enters, start && !busy, valid_s1)
	// A stall keeps the final stage occupied.
	`SITOA_ASSERT_NEXT(a_stall_holds, busy, len_valid_s)

endmodule

/* hdl/sitoa_dabble_stage.sv */
// ----------------------------------------------------------------------------
// sitoa_dabble_stage
// One pipeline stage of the binary to BCD conversion: shifts STEP_BITS
// magnitude bits into the BCD accumulator with add-3 correction.
// ----------------------------------------------------------------------------
module sitoa_dabble_stage #(
	parameter int MAG_W  = 32,
	parameter int DIGITS = 10
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               adv,
	input  logic                               in_valid,
	input  logic                               in_neg,
	input  logic [MAG_W-1:0]                   in_mag,
	input  logic [DIGITS*sitoa_pkg::DIGIT_W-1:0] in_bcd,
	output logic                               valid_s1,
	output logic                               neg_s1,
	output logic [MAG_W-1:0]                   mag_s1,
	output logic [DIGITS*sitoa_pkg::DIGIT_W-1:0] bcd_s1
);

	localparam int BCD_W = DIGITS * sitoa_pkg::DIGIT_W;

	logic [BCD_W-1:0] bcd_c;
	logic [MAG_W-1:0] mag_c;

	// Double-dabble steps: correct each digit, then shift one bit in.
	always_comb begin
		bcd_c = in_bcd;
		mag_c = in_mag;
		for (int s = 0; s < sitoa_pkg::STEP_BITS; s++) begin
			for (int d = 0; d < DIGITS; d++) begin
				if (bcd_c[d*sitoa_pkg::DIGIT_W +: sitoa_pkg::DIGIT_W] >= 4'd5) begin
					bcd_c[d*sitoa_pkg::DIGIT_W +: sitoa_pkg::DIGIT_W] =
						bcd_c[d*sitoa_pkg::DIGIT_W +: sitoa_pkg::DIGIT_W] + 4'd3;
				end
			end
			bcd_c = {bcd_c[BCD_W-2:0], mag_c[MAG_W-1]};
			mag_c = {mag_c[MAG_W-2:0], 1'b0};
		end
	end

	// Stage valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s1 <= in_neg;
			mag_s1 <= mag_c;
			bcd_s1 <= bcd_c;
		end
	end

endmodule

/* hdl/sitoa_serializer.sv */
// ----------------------------------------------------------------------------
// sitoa_serializer
// Emits the sign and the significant BCD digits as ASCII characters, one
// per cycle, most significant first, flagging the final character.
// ----------------------------------------------------------------------------
module sitoa_serializer #(
	parameter int DIGITS = 10,
	parameter int NDIG_W = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 load,
	input  logic                                 neg,
	input  logic [DIGITS*sitoa_pkg::DIGIT_W-1:0] bcd,
	input  logic [NDIG_W-1:0]                    ndig,
	output logic                                 ready,
	output logic                                 strobe,
	output logic [7:0]                           character,
	output logic                                 last
);

	localparam int BCD_W = DIGITS * sitoa_pkg::DIGIT_W;
	localparam int IDX_W = $clog2(DIGITS);

	logic                active_q;
	logic                sign_q;
	logic [IDX_W-1:0]    idx_q;
	logic [BCD_W-1:0]    bcd_q;
	logic [sitoa_pkg::DIGIT_W-1:0] digit;
	logic                final_c;

	assign digit   = bcd_q[idx_q*sitoa_pkg::DIGIT_W +: sitoa_pkg::DIGIT_W];
	assign final_c = active_q && !sign_q && (idx_q == '0);

	// A new value may be taken when idle or while the final digit goes out.
	assign ready = !active_q || final_c;

	// Sequencing control. A load replaces the step of the value in progress.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			sign_q   <= 1'b0;
			idx_q    <= '0;
			strobe   <= 1'b0;
		end else begin
			strobe <= active_q;
			if (load) begin
				active_q <= 1'b1;
				sign_q   <= neg;
				idx_q    <= IDX_W'(ndig - 1'b1);
			end else if (active_q) begin
				if (sign_q) begin
					sign_q <= 1'b0;
				end else if (idx_q != '0) begin
					idx_q <= idx_q - 1'b1;
				end else begin
					active_q <= 1'b0;
				end
			end
		end
	end

	// Digit store and output character.
	always_ff @(posedge clk) begin
		if (load) begin
			bcd_q <= bcd;
		end
		if (active_q) begin
			if (sign_q) begin
				character <= sitoa_pkg::CHAR_MINUS;
				last      <= 1'b0;
			end else begin
				character <= sitoa_pkg::CHAR_ZERO + 8'(digit);
				last      <= (idx_q == '0);
			end
		end
	end

endmodule
